// ----- src/mfde_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and pixel address mapping for the draw engine.
package mfde_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int ROW_BYTES   = MAX_WIDTH / 8;
   localparam int STORE_BYTES = ROW_BYTES * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int DIM_W       = $clog2(MAX_WIDTH) + 1;
   localparam int HGT_W       = $clog2(MAX_HEIGHT) + 1;
   localparam int RB_W        = $clog2(ROW_BYTES) + 1;

   typedef logic signed [11:0] coord_type;
   typedef logic signed [12:0] err_type;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_PIXEL = 3'd1,
      OP_LINE  = 3'd2,
      OP_RECT  = 3'd3,
      OP_CIRC  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_ROT    = 2'd2,
      REG_INVERT = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CLR,
      S_LINE_PLOT, S_LINE_STEP,
      S_RECT_PLOT, S_RECT_STEP,
      S_CIRC_PLOT, S_CIRC_STEP,
      S_PX_ADDR, S_PX_READ, S_PX_WRITE,
      S_RD_ISSUE, S_RD_DATA, S_RESP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        bitpos;
   } pix_loc_type;

   function automatic logic [DIM_W-1:0] eff_width(input logic [8:0] fw);
      logic [9:0] t;
      t = {1'b0, fw} + 10'd7;
      t[2:0] = 3'b000;
      if (t < 10'd8) t = 10'd8;
      if (t > 10'(MAX_WIDTH)) t = 10'(MAX_WIDTH);
      return DIM_W'(t);
   endfunction

   function automatic logic [HGT_W-1:0] eff_height(input logic [8:0] fh);
      logic [9:0] t;
      t = {1'b0, fh};
      if (t < 10'd1) t = 10'd1;
      if (t > 10'(MAX_HEIGHT)) t = 10'(MAX_HEIGHT);
      return HGT_W'(t);
   endfunction

   // Rotate, bounds check and turn a pixel into a byte address and bit.
   function automatic pix_loc_type map_pixel(input coord_type x, input coord_type y,
                                             input logic [DIM_W-1:0] w,
                                             input logic [HGT_W-1:0] h,
                                             input logic [1:0] rot);
      coord_type   xr, yr, ws, hs;
      pix_loc_type r;
      logic [RB_W-1:0] rb;
      logic [ADDR_W+RB_W-1:0] prod;
      ws = coord_type'({1'b0, w});
      hs = coord_type'({1'b0, h});
      case (rot_type'(rot))
         ROT_90:  begin xr = ws - 12'sd1 - y; yr = x; end
         ROT_180: begin xr = ws - 12'sd1 - x; yr = hs - 12'sd1 - y; end
         ROT_270: begin xr = y; yr = hs - 12'sd1 - x; end
         default: begin xr = x; yr = y; end
      endcase
      r.ok = (xr >= 12'sd0) && (yr >= 12'sd0) && (xr < ws) && (yr < hs);
      rb = RB_W'(w >> 3);
      prod = ADDR_W'(yr[7:0]) * rb + (ADDR_W + RB_W)'(xr[7:3]);
      r.addr = prod[ADDR_W-1:0];
      r.bitpos = xr[2:0];
      return r;
   endfunction

endpackage

// ----- src/mfde_ram.sv -----
`timescale 1ns / 1ps
// Frame store: one write port, one registered read port.
module mfde_ram
   import mfde_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);

   logic [7:0] mem_ff [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/mfde_seq.sv -----
`timescale 1ns / 1ps
// Command sequencer: shape walkers feeding one shared pixel read-modify-write unit.
module mfde_seq
   import mfde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_x_a,
   input  logic [7:0]        req_y_a,
   input  logic [7:0]        req_x_b,
   input  logic [7:0]        req_y_b,
   input  logic [7:0]        req_circle_radius,
   input  logic              req_pen_color,
   input  logic              req_fill_shape,
   input  logic [12:0]       req_byte_address,
   input  logic [DIM_W-1:0]  eff_w,
   input  logic [HGT_W-1:0]  eff_h,
   input  logic [1:0]        rot,
   input  logic              invert,
   output mem_req_type       mem_req,
   input  logic [7:0]        mem_rdata,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_was_read
);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic bit_ff, bit_in, fill_ff, fill_in, ph_ff, ph_in, was_read_ff, was_read_in;
   logic sxn_ff, sxn_in, syn_ff, syn_in;
   logic [1:0] k_ff, k_in;
   logic [9:0] i_ff, i_in;
   coord_type a_x_ff, a_x_in, a_y_ff, a_y_in, b_x_ff, b_x_in, b_y_ff, b_y_in;
   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type dx_ff, dx_in, dy_ff, dy_in, xp_ff, xp_in, yp_ff, yp_in;
   coord_type px_x_ff, px_x_in, px_y_ff, px_y_in;
   err_type err_ff, err_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0] bitpos_ff, bitpos_in;
   logic [7:0] rd_ff, rd_in;

   pix_loc_type loc;
   logic [CNT_W-1:0] clr_total;
   logic [ADDR_W+RB_W-1:0] clr_prod;
   coord_type xa_s, ya_s, xb_s, yb_s, rad_s;
   logic line_last, rect_last, circ_iter_end, circ_last;
   coord_type circ_xn, circ_yn;
   err_type circ_en, e2c, e2l;
   logic [7:0] mask;

   assign xa_s = coord_type'({4'b0, req_x_a});
   assign ya_s = coord_type'({4'b0, req_y_a});
   assign xb_s = coord_type'({4'b0, req_x_b});
   assign yb_s = coord_type'({4'b0, req_y_b});
   assign rad_s = coord_type'({4'b0, req_circle_radius});

   assign loc = map_pixel(px_x_ff, px_y_ff, eff_w, eff_h, rot);
   assign clr_prod = (ADDR_W + RB_W)'(eff_h) * RB_W'(eff_w >> 3);
   assign clr_total = CNT_W'(clr_prod);
   assign mask = 8'h80 >> bitpos_ff;

   assign line_last = (cur_x_ff == b_x_ff) && (cur_y_ff == b_y_ff);
   assign rect_last = fill_ff ? ((cur_y_ff >= b_y_ff) && (cur_x_ff >= b_x_ff))
                              : (ph_ff && k_ff[0] && (cur_y_ff >= b_y_ff));
   assign circ_iter_end = fill_ff
      ? (k_ff[0] && (coord_type'({2'b0, i_ff}) >= -(xp_ff <<< 1)))
      : (k_ff == 2'd3);
   assign circ_last = circ_iter_end && (circ_xn > 12'sd0);

   // One Bresenham circle step.
   always_comb begin
      e2c = err_ff;
      circ_xn = xp_ff;
      circ_yn = yp_ff;
      circ_en = err_ff;
      if (e2c <= err_type'(yp_ff)) begin
         circ_yn = yp_ff + 12'sd1;
         circ_en = circ_en + (err_type'(circ_yn) <<< 1) + 13'sd1;
         if ((-xp_ff == circ_yn) && (err_ff <= err_type'(xp_ff))) e2c = '0;
      end
      if (e2c > err_type'(xp_ff)) begin
         circ_xn = xp_ff + 12'sd1;
         circ_en = circ_en + (err_type'(circ_xn) <<< 1) + 13'sd1;
      end
   end

   assign e2l = err_ff <<< 1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: if (cnt_ff == CNT_W'(STORE_BYTES - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               case (op_type'(req_op))
                  OP_CLEAR: state_in = S_CLR;
                  OP_PIXEL: state_in = S_PX_ADDR;
                  OP_LINE:  state_in = S_LINE_PLOT;
                  OP_RECT:  state_in = S_RECT_PLOT;
                  OP_CIRC:  state_in = S_CIRC_PLOT;
                  OP_READ:  state_in = S_RD_ISSUE;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_CLR: if (cnt_ff + CNT_W'(1) >= clr_total) state_in = S_RESP;
         S_LINE_PLOT, S_RECT_PLOT, S_CIRC_PLOT: state_in = S_PX_ADDR;
         S_LINE_STEP: state_in = line_last ? S_RESP : S_LINE_PLOT;
         S_RECT_STEP: state_in = rect_last ? S_RESP : S_RECT_PLOT;
         S_CIRC_STEP: state_in = circ_last ? S_RESP : S_CIRC_PLOT;
         S_PX_ADDR: state_in = loc.ok ? S_PX_READ : ret_ff;
         S_PX_READ: state_in = S_PX_WRITE;
         S_PX_WRITE: state_in = ret_ff;
         S_RD_ISSUE: state_in = S_RD_DATA;
         S_RD_DATA: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      rsp_read_data = rd_ff;
      rsp_was_read = was_read_ff;
      mem_req.we = 1'b0;
      mem_req.waddr = cnt_ff[ADDR_W-1:0];
      mem_req.wdata = 8'hFF;
      mem_req.raddr = addr_ff;
      case (state_ff)
         S_INIT: mem_req.we = 1'b1;
         S_CLR: begin
            mem_req.we = 1'b1;
            mem_req.wdata = {8{bit_ff}};
         end
         S_PX_WRITE: begin
            mem_req.we = 1'b1;
            mem_req.waddr = addr_ff;
            mem_req.wdata = bit_ff ? (mem_rdata | mask) : (mem_rdata & ~mask);
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      ret_in = ret_ff; cnt_in = cnt_ff; bit_in = bit_ff; fill_in = fill_ff;
      ph_in = ph_ff; was_read_in = was_read_ff; sxn_in = sxn_ff; syn_in = syn_ff;
      k_in = k_ff; i_in = i_ff; a_x_in = a_x_ff; a_y_in = a_y_ff;
      b_x_in = b_x_ff; b_y_in = b_y_ff; cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      dx_in = dx_ff; dy_in = dy_ff; xp_in = xp_ff; yp_in = yp_ff;
      px_x_in = px_x_ff; px_y_in = px_y_ff; err_in = err_ff;
      addr_in = addr_ff; bitpos_in = bitpos_ff; rd_in = rd_ff;
      case (state_ff)
         S_INIT: cnt_in = cnt_ff + CNT_W'(1);
         S_IDLE: begin
            if (start) begin
               bit_in = req_pen_color ^ invert;
               fill_in = req_fill_shape;
               rd_in = '0;
               was_read_in = 1'b0;
               cnt_in = '0;
               k_in = '0;
               i_in = '0;
               ph_in = 1'b0;
               px_x_in = xa_s;
               px_y_in = ya_s;
               ret_in = S_RESP;
               addr_in = req_byte_address;
               cur_x_in = xa_s;
               cur_y_in = ya_s;
               b_x_in = xb_s;
               b_y_in = yb_s;
               dx_in = (xb_s > xa_s) ? (xb_s - xa_s) : (xa_s - xb_s);
               dy_in = (yb_s > ya_s) ? (ya_s - yb_s) : (yb_s - ya_s);
               err_in = err_type'(dx_in) + err_type'(dy_in);
               sxn_in = !(xa_s < xb_s);
               syn_in = !(ya_s < yb_s);
               a_x_in = xa_s;
               a_y_in = ya_s;
               if (op_type'(req_op) == OP_RECT) begin
                  a_x_in = (xa_s < xb_s) ? xa_s : xb_s;
                  b_x_in = (xa_s < xb_s) ? xb_s : xa_s;
                  a_y_in = (ya_s < yb_s) ? ya_s : yb_s;
                  b_y_in = (ya_s < yb_s) ? yb_s : ya_s;
                  cur_x_in = a_x_in;
                  cur_y_in = a_y_in;
               end
               if (op_type'(req_op) == OP_CIRC) begin
                  xp_in = -rad_s;
                  yp_in = '0;
                  err_in = 13'sd2 - (err_type'(rad_s) <<< 1);
               end
               if (op_type'(req_op) == OP_READ) was_read_in = 1'b1;
            end
         end
         S_CLR: cnt_in = cnt_ff + CNT_W'(1);
         S_LINE_PLOT: begin
            px_x_in = cur_x_ff;
            px_y_in = cur_y_ff;
            ret_in = S_LINE_STEP;
         end
         S_LINE_STEP: begin
            if (!line_last) begin
               err_in = err_ff;
               if (e2l >= err_type'(dy_ff)) begin
                  err_in = err_in + err_type'(dy_ff);
                  cur_x_in = sxn_ff ? cur_x_ff - 12'sd1 : cur_x_ff + 12'sd1;
               end
               if (e2l <= err_type'(dx_ff)) begin
                  err_in = err_in + err_type'(dx_ff);
                  cur_y_in = syn_ff ? cur_y_ff - 12'sd1 : cur_y_ff + 12'sd1;
               end
            end
         end
         S_RECT_PLOT: begin
            ret_in = S_RECT_STEP;
            if (fill_ff) begin
               px_x_in = cur_x_ff; px_y_in = cur_y_ff;
            end else if (!ph_ff) begin
               px_x_in = cur_x_ff; px_y_in = k_ff[0] ? b_y_ff : a_y_ff;
            end else begin
               px_x_in = k_ff[0] ? b_x_ff : a_x_ff; px_y_in = cur_y_ff;
            end
         end
         S_RECT_STEP: begin
            if (fill_ff) begin
               if (cur_y_ff < b_y_ff) cur_y_in = cur_y_ff + 12'sd1;
               else begin
                  cur_y_in = a_y_ff;
                  cur_x_in = cur_x_ff + 12'sd1;
               end
            end else begin
               k_in = {1'b0, !k_ff[0]};
               if (k_ff[0]) begin
                  if (!ph_ff) begin
                     if (cur_x_ff < b_x_ff) cur_x_in = cur_x_ff + 12'sd1;
                     else ph_in = 1'b1;
                  end else begin
                     cur_y_in = cur_y_ff + 12'sd1;
                  end
               end
            end
         end
         S_CIRC_PLOT: begin
            ret_in = S_CIRC_STEP;
            if (fill_ff) begin
               px_x_in = a_x_ff + xp_ff + coord_type'({2'b0, i_ff});
               px_y_in = k_ff[0] ? (a_y_ff - yp_ff) : (a_y_ff + yp_ff);
            end else begin
               case (k_ff)
                  2'd0: begin px_x_in = a_x_ff - xp_ff; px_y_in = a_y_ff + yp_ff; end
                  2'd1: begin px_x_in = a_x_ff + xp_ff; px_y_in = a_y_ff + yp_ff; end
                  2'd2: begin px_x_in = a_x_ff + xp_ff; px_y_in = a_y_ff - yp_ff; end
                  default: begin px_x_in = a_x_ff - xp_ff; px_y_in = a_y_ff - yp_ff; end
               endcase
            end
         end
         S_CIRC_STEP: begin
            if (circ_iter_end) begin
               k_in = '0;
               i_in = '0;
               xp_in = circ_xn;
               yp_in = circ_yn;
               err_in = circ_en;
            end else if (fill_ff) begin
               if (coord_type'({2'b0, i_ff}) >= -(xp_ff <<< 1)) begin
                  i_in = '0;
                  k_in = 2'd1;
               end else begin
                  i_in = i_ff + 10'd1;
               end
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_PX_ADDR: begin
            addr_in = loc.addr;
            bitpos_in = loc.bitpos;
         end
         S_RD_DATA: rd_in = mem_rdata;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ret_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in; fill_ff <= fill_in; ph_ff <= ph_in; was_read_ff <= was_read_in;
      sxn_ff <= sxn_in; syn_ff <= syn_in; k_ff <= k_in; i_ff <= i_in;
      a_x_ff <= a_x_in; a_y_ff <= a_y_in; b_x_ff <= b_x_in; b_y_ff <= b_y_in;
      cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in; dx_ff <= dx_in; dy_ff <= dy_in;
      xp_ff <= xp_in; yp_ff <= yp_in; px_x_ff <= px_x_in; px_y_ff <= px_y_in;
      err_ff <= err_in; addr_ff <= addr_in; bitpos_ff <= bitpos_in; rd_ff <= rd_in;
   end

endmodule

// ----- src/mono_framebuffer_draw_engine_core.sv -----
`timescale 1ns / 1ps
// Shapes send each plotted pixel through address, read and write states on the frame
// store (one write port, one read port), plus a plot and a step state per walker step.
// Throughput: one command at a time; busy stays high until the result strobe ends.
// Reset: all 8192 bytes of the store are swept to 0xFF, with busy high meanwhile.
// rsp_valid pulses for one cycle per command; the receiver cannot stall it.
module mono_framebuffer_draw_engine_core
   import mfde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_x_a,
   input  logic [7:0]  req_y_a,
   input  logic [7:0]  req_x_b,
   input  logic [7:0]  req_y_b,
   input  logic [7:0]  req_circle_radius,
   input  logic        req_pen_color,
   input  logic        req_fill_shape,
   input  logic [12:0] req_byte_address,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_was_read,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_write_data
);

   logic [8:0] width_ff, height_ff;
   logic [1:0] rot_ff;
   logic       invert_ff;
   mem_req_type mem_req;
   logic [7:0] mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         rot_ff <= '0;
         invert_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (reg_type'(csr_index))
            REG_WIDTH:  width_ff <= csr_write_data;
            REG_HEIGHT: height_ff <= csr_write_data;
            REG_ROT:    rot_ff <= csr_write_data[1:0];
            REG_INVERT: invert_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   mfde_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_x_a(req_x_a), .req_y_a(req_y_a),
      .req_x_b(req_x_b), .req_y_b(req_y_b), .req_circle_radius(req_circle_radius),
      .req_pen_color(req_pen_color), .req_fill_shape(req_fill_shape),
      .req_byte_address(req_byte_address),
      .eff_w(eff_width(width_ff)), .eff_h(eff_height(height_ff)),
      .rot(rot_ff), .invert(invert_ff),
      .mem_req(mem_req), .mem_rdata(mem_rdata),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data), .rsp_was_read(rsp_was_read)
   );

   mfde_ram u_ram (
      .clock(clock), .mem_req(mem_req), .rdata(mem_rdata)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the monochrome frame store draw engine.
module tb;
   import mfde_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int LIMIT_CYCLES = 12000000;
   localparam int ITEMS_TOTAL = 1550;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  xa, ya, xb, yb, rad;
      logic        pen, fill;
      logic [12:0] addr;
   } draw_cmd_type;

   typedef struct {
      logic [7:0] data;
      logic       rd;
   } read_back_type;

   logic        clock, reset, start, busy;
   logic [2:0]  req_op;
   logic [7:0]  req_x_a, req_y_a, req_x_b, req_y_b, req_circle_radius;
   logic        req_pen_color, req_fill_shape;
   logic [12:0] req_byte_address;
   logic        rsp_valid, rsp_was_read;
   logic [7:0]  rsp_read_data;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [8:0]  csr_write_data;

   mono_framebuffer_draw_engine_core dut (.*);

   draw_cmd_type  cmd_queue[$];
   read_back_type read_backs[$];
   draw_cmd_type  cur_cmd;
   logic       taken;
   int         burst_left, gap_left, cycles;
   bit         failed;

   // shadow frame store and registers
   logic [7:0] pix_mem [STORE_BYTES];
   logic [8:0] sh_width, sh_height;
   logic [1:0] sh_rot;
   logic       sh_inv;

   function automatic int frame_w();
      int w;
      w = (int'(sh_width) + 7) & ~7;
      if (w < 8) w = 8;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int frame_h();
      int h;
      h = int'(sh_height);
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic void put_pixel(int x, int y, logic b);
      int w, h, idx;
      w = frame_w();
      h = frame_h();
      if (x < 0 || y < 0 || x >= w || y >= h) return;
      idx = y * (w / 8) + x / 8;
      if (idx >= STORE_BYTES) return;
      pix_mem[idx][7 - (x % 8)] = b;
   endfunction

   function automatic void plot_rot(int x, int y, logic b);
      int w, h, t;
      w = frame_w();
      h = frame_h();
      case (rot_type'(sh_rot))
         ROT_90: begin t = x; x = w - 1 - y; y = t; end
         ROT_180: begin x = w - 1 - x; y = h - 1 - y; end
         ROT_270: begin t = x; x = y; y = h - 1 - t; end
         default: ;
      endcase
      put_pixel(x, y, b);
   endfunction

   function automatic void draw_line(int x0, int y0, int x1, int y1, logic b);
      int dx, dy, sx, sy, err, e2;
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      dy = y1 > y0 ? y0 - y1 : y1 - y0;
      sx = x0 < x1 ? 1 : -1;
      sy = y0 < y1 ? 1 : -1;
      err = dx + dy;
      while (1) begin
         plot_rot(x0, y0, b);
         if (x0 == x1 && y0 == y1) break;
         e2 = 2 * err;
         if (e2 >= dy) begin err += dy; x0 += sx; end
         if (e2 <= dx) begin err += dx; y0 += sy; end
      end
   endfunction

   function automatic void draw_rect(int x0, int y0, int x1, int y1, logic b, logic f);
      int lx, hx, ly, hy;
      lx = x0 < x1 ? x0 : x1;
      hx = x0 < x1 ? x1 : x0;
      ly = y0 < y1 ? y0 : y1;
      hy = y0 < y1 ? y1 : y0;
      if (f) begin
         for (int i = lx; i <= hx; i++)
            for (int j = ly; j <= hy; j++) plot_rot(i, j, b);
      end else begin
         for (int i = lx; i <= hx; i++) begin plot_rot(i, ly, b); plot_rot(i, hy, b); end
         for (int j = ly; j <= hy; j++) begin plot_rot(lx, j, b); plot_rot(hx, j, b); end
      end
   endfunction

   function automatic void draw_circle(int cx, int cy, int r, logic b, logic f);
      int xp, yp, err, e2;
      xp = -r;
      yp = 0;
      err = 2 - 2 * r;
      do begin
         plot_rot(cx - xp, cy + yp, b);
         plot_rot(cx + xp, cy + yp, b);
         plot_rot(cx + xp, cy - yp, b);
         plot_rot(cx - xp, cy - yp, b);
         if (f) begin
            for (int i = 0; i < 2 * (-xp) + 1; i++) begin
               plot_rot(cx + xp + i, cy + yp, b);
               plot_rot(cx + xp + i, cy - yp, b);
            end
         end
         e2 = err;
         if (e2 <= yp) begin
            yp++;
            err += yp * 2 + 1;
            if (-xp == yp && e2 <= xp) e2 = 0;
         end
         if (e2 > xp) begin
            xp++;
            err += xp * 2 + 1;
         end
      end while (xp <= 0);
   endfunction

   // Apply one command to the shadow store and return the word it answers with.
   function automatic read_back_type run_cmd(draw_cmd_type c);
      read_back_type r;
      logic b;
      r.data = 8'd0;
      r.rd = 1'b0;
      b = c.pen ^ sh_inv;
      case (c.op)
         OP_CLEAR: begin
            for (int y = 0; y < frame_h(); y++)
               for (int x = 0; x < frame_w(); x++) put_pixel(x, y, b);
         end
         OP_PIXEL: plot_rot(c.xa, c.ya, b);
         OP_LINE: draw_line(c.xa, c.ya, c.xb, c.yb, b);
         OP_RECT: draw_rect(c.xa, c.ya, c.xb, c.yb, b, c.fill);
         OP_CIRC: draw_circle(c.xa, c.ya, c.rad, b, c.fill);
         OP_READ: begin
            r.data = pix_mem[c.addr];
            r.rd = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic draw_cmd_type mk_cmd(logic [2:0] op, int xa, int ya, int xb, int yb,
                                           int rad, logic pen, logic fill, int addr);
      draw_cmd_type c;
      c.op = op; c.xa = 8'(xa); c.ya = 8'(ya); c.xb = 8'(xb); c.yb = 8'(yb);
      c.rad = 8'(rad); c.pen = pen; c.fill = fill; c.addr = 13'(addr);
      return c;
   endfunction

   function automatic logic [7:0] near(logic [7:0] v, int span);
      return v + 8'($urandom_range(0, 2 * span) - span);
   endfunction

   // Mostly small shapes with random content, a few spanning the whole frame.
   function automatic draw_cmd_type rand_cmd();
      draw_cmd_type c;
      int sel;
      logic wide;
      c.xa = 8'($urandom); c.ya = 8'($urandom); c.pen = 1'($urandom);
      c.fill = 1'($urandom); c.addr = 13'($urandom); c.rad = 8'($urandom);
      wide = ($urandom_range(0, 15) == 0);
      c.xb = wide ? 8'($urandom) : near(c.xa, 12);
      c.yb = wide ? 8'($urandom) : near(c.ya, 12);
      sel = int'($urandom_range(0, 99));
      if (sel < 2) c.op = OP_CLEAR;
      else if (sel < 4) c.op = ($urandom_range(0, 1)) ? OP_SPARE_A : OP_SPARE_B;
      else if (sel < 16) c.op = OP_PIXEL;
      else if (sel < 30) c.op = OP_LINE;
      else if (sel < 44) c.op = OP_RECT;
      else if (sel < 60) c.op = OP_CIRC;
      else c.op = OP_READ;
      if (c.op == OP_RECT && c.fill && wide) c.xb = near(c.xa, 12);
      if (c.op == OP_CIRC) c.rad = (wide && !c.fill) ? 8'($urandom) : 8'($urandom_range(0, 15));
      // bias reads toward the low rows where narrow frames keep their pixels
      if (c.op == OP_READ && $urandom_range(0, 1)) c.addr = 13'($urandom_range(0, 511));
      return c;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // monitor: check results, then record the word accepted at this edge
   always @(posedge clock) begin
      read_back_type e;
      if (!reset && rsp_valid) begin
         if (read_backs.size() == 0) begin
            $error("unexpected result read_data=%0h was_read=%0b", rsp_read_data, rsp_was_read);
            failed = 1'b1;
         end else begin
            e = read_backs.pop_front();
            if (rsp_read_data !== e.data) begin
               $error("read_data expected %0h got %0h", e.data, rsp_read_data);
               failed = 1'b1;
            end
            if (rsp_was_read !== e.rd) begin
               $error("was_read expected %0b got %0b", e.rd, rsp_was_read);
               failed = 1'b1;
            end
         end
      end
      taken <= start && !busy && !reset;
      if (start && !busy && !reset) read_backs.push_back(run_cmd(cur_cmd));
   end

   // driver: bursts of words with random gaps
   always @(negedge clock) begin
      if (!(start && !taken)) begin
         if (gap_left > 0 || cmd_queue.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            cur_cmd = cmd_queue.pop_front();
            start <= 1'b1;
            req_op <= cur_cmd.op;
            req_x_a <= cur_cmd.xa;
            req_y_a <= cur_cmd.ya;
            req_x_b <= cur_cmd.xb;
            req_y_b <= cur_cmd.yb;
            req_circle_radius <= cur_cmd.rad;
            req_pen_color <= cur_cmd.pen;
            req_fill_shape <= cur_cmd.fill;
            req_byte_address <= cur_cmd.addr;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   task automatic write_reg(reg_type idx, logic [8:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      case (idx)
         REG_WIDTH: sh_width = v;
         REG_HEIGHT: sh_height = v;
         REG_ROT: sh_rot = v[1:0];
         default: sh_inv = v[0];
      endcase
   endtask

   task automatic set_frame(logic [8:0] w, logic [8:0] h, logic [1:0] r, logic inv);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_ROT, 9'(r));
      write_reg(REG_INVERT, 9'(inv));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      while (cmd_queue.size() != 0 || start || read_backs.size() != 0 || busy)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [8:0] pw, ph;
      start = 1'b0;
      req_op = OP_CLEAR;
      req_x_a = '0; req_y_a = '0; req_x_b = '0; req_y_b = '0; req_circle_radius = '0;
      req_pen_color = 1'b0; req_fill_shape = 1'b0; req_byte_address = '0;
      csr_write_en = 1'b0; csr_index = REG_WIDTH; csr_write_data = '0;
      taken = 1'b0; burst_left = 0; gap_left = 0; cycles = 0; failed = 1'b0;
      sh_width = 9'd256; sh_height = 9'd256; sh_rot = ROT_0; sh_inv = 1'b0;
      for (int i = 0; i < STORE_BYTES; i++) pix_mem[i] = 8'hFF;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (busy) @(posedge clock);

      // directed: edges of every field, all ops, large shapes
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 8191));
      cmd_queue.push_back(mk_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_PIXEL, 255, 255, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 8191));
      cmd_queue.push_back(mk_cmd(OP_LINE, 0, 0, 255, 255, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_LINE, 200, 250, 3, 10, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_LINE, 40, 40, 40, 40, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_RECT, 255, 255, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_RECT, 20, 9, 10, 2, 0, 0, 1, 0));
      cmd_queue.push_back(mk_cmd(OP_CIRC, 128, 128, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_CIRC, 128, 128, 0, 0, 255, 0, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_CIRC, 5, 250, 0, 0, 30, 0, 1, 0));
      cmd_queue.push_back(mk_cmd(OP_SPARE_A, 1, 1, 1, 1, 1, 0, 1, 4));
      cmd_queue.push_back(mk_cmd(OP_SPARE_B, 1, 1, 1, 1, 1, 1, 1, 4));
      for (int i = 0; i < 6; i++)
         cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 8191)));
      cmd_queue.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0));
      cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 8191));
      drain();

      // random phases over several frame settings, extremes first
      for (int ph_i = 0; ph_i < 7; ph_i++) begin
         case (ph_i)
            0: begin pw = 9'd8; ph = 9'd1; end
            1: begin pw = 9'd0; ph = 9'd0; end
            2: begin pw = 9'd511; ph = 9'd511; end
            3: begin pw = 9'd256; ph = 9'd256; end
            default: begin pw = 9'($urandom); ph = 9'($urandom); end
         endcase
         set_frame(pw, ph, 2'(ph_i % 4), 1'((ph_i >> 1) & 1));
         for (int i = 0; i < ITEMS_TOTAL / 7; i++) cmd_queue.push_back(rand_cmd());
         drain();
      end

      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
